// ===== rtl/core/dnv_pkg.sv =====
`timescale 1ns / 1ps

package dnv_pkg;

  localparam int CHAR_W   = 16;
  localparam int DOM_W    = 10;
  localparam int LABEL_W  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DOMAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LABEL  = 1'd1;

  localparam logic [DOM_W-1:0]   MAX_DOMAIN_RST = 10'd253;
  localparam logic [LABEL_W-1:0] MAX_LABEL_RST  = 8'd63;

  localparam logic [CHAR_W-1:0] CH_HYPHEN   = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_DOT      = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A  = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 16'h007A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

  typedef struct packed {
    logic upper;
    logic lower;
    logic digit;
    logic hyphen;
    logic dot;
  } char_class_t;

endpackage

// ===== rtl/core/dnv_in_if.sv =====
`timescale 1ns / 1ps

interface dnv_in_if;
  logic                        valid;
  logic                        ready;
  logic [dnv_pkg::CHAR_W-1:0]  character;
  logic                        is_last;

  modport source (output valid, character, is_last, input ready);
  modport sink   (input valid, character, is_last, output ready);
endinterface

// ===== rtl/core/dnv_out_if.sv =====
`timescale 1ns / 1ps

interface dnv_out_if;
  logic                        valid;
  logic                        ready;
  logic [dnv_pkg::CHAR_W-1:0]  lower_char;
  logic                        end_of_name;
  logic                        name_valid;

  modport source (output valid, lower_char, end_of_name, name_valid, input ready);
  modport sink   (input valid, lower_char, end_of_name, name_valid, output ready);
endinterface

// ===== rtl/core/dnv_char_class.sv =====
`timescale 1ns / 1ps

module dnv_char_class (
  input  logic [dnv_pkg::CHAR_W-1:0] character,
  output dnv_pkg::char_class_t       cls,
  output logic [dnv_pkg::CHAR_W-1:0] lower_char
);

  always_comb begin
    cls.upper  = (character >= dnv_pkg::CH_UPPER_A) && (character <= dnv_pkg::CH_UPPER_Z);
    cls.lower  = (character >= dnv_pkg::CH_LOWER_A) && (character <= dnv_pkg::CH_LOWER_Z);
    cls.digit  = (character >= dnv_pkg::CH_DIGIT_0) && (character <= dnv_pkg::CH_DIGIT_9);
    cls.hyphen = (character == dnv_pkg::CH_HYPHEN);
    cls.dot    = (character == dnv_pkg::CH_DOT);
  end

  assign lower_char = cls.upper ? (character + dnv_pkg::CASE_OFFSET) : character;

endmodule

// ===== rtl/core/domain_name_validator_core.sv =====
`timescale 1ns / 1ps

// Hostname checker: takes one 16-bit character per beat and returns one beat per character,
// ASCII upper case folded to lower case; the beat carrying is_last also carries the verdict.
// Throughput is one character per cycle while out_ch.ready stays high; each character passes
// through an input register, then a result register, the per-name flags and counters updating
// as a character leaves the input register. in_ch.ready is high while either register is empty
// or out_ch.ready is high, so a held result stalls the input only once both registers are full.
// Write the length limits only while no name is in flight.
module domain_name_validator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dnv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dnv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  dnv_in_if.sink                            in_ch,
  dnv_out_if.source                         out_ch
);

  logic [dnv_pkg::DOM_W-1:0]   max_domain;
  logic [dnv_pkg::LABEL_W-1:0] max_label;

  logic                        s1_valid;
  logic [dnv_pkg::CHAR_W-1:0]  s1_char;
  logic                        s1_last;

  logic                        o_valid;
  logic [dnv_pkg::CHAR_W-1:0]  o_char;
  logic                        o_last;
  logic                        o_verdict;

  logic [dnv_pkg::LABEL_W-1:0] label_count, label_count_next;
  logic [dnv_pkg::DOM_W-1:0]   total_count, total_count_next;
  logic                        prev_was_hyphen, prev_was_hyphen_next;
  logic                        saw_letter, saw_letter_next;
  logic                        failed, failed_next;
  logic                        verdict_next;

  dnv_pkg::char_class_t        cls;
  logic [dnv_pkg::CHAR_W-1:0]  lowered;
  logic [dnv_pkg::DOM_W:0]     new_total;
  logic [dnv_pkg::LABEL_W:0]   new_label;
  logic [dnv_pkg::LABEL_W-1:0] label_upd;
  logic                        hyph_upd;
  logic                        fail_upd;
  logic                        adv_out, adv_s1;

  dnv_char_class u_class (
    .character  (s1_char),
    .cls        (cls),
    .lower_char (lowered)
  );

  assign adv_out      = !o_valid || out_ch.ready;
  assign adv_s1       = s1_valid && adv_out;
  assign in_ch.ready  = !s1_valid || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_domain <= dnv_pkg::MAX_DOMAIN_RST;
      max_label  <= dnv_pkg::MAX_LABEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dnv_pkg::REG_MAX_DOMAIN: max_domain <= cfg_wdata[dnv_pkg::DOM_W-1:0];
        dnv_pkg::REG_MAX_LABEL:  max_label  <= cfg_wdata[dnv_pkg::LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    new_total = {1'b0, total_count} + 1'b1;
    new_label = {1'b0, label_count} + 1'b1;
    fail_upd  = failed || (new_total > {1'b0, max_domain});
    if (cls.dot) begin
      if (label_count == '0 || prev_was_hyphen) begin
        fail_upd = 1'b1;
      end
      label_upd = '0;
      hyph_upd  = 1'b0;
    end else begin
      if (!cls.upper && !cls.lower && !cls.digit && !cls.hyphen) begin
        fail_upd = 1'b1;
      end
      if (label_count == '0 && cls.hyphen) begin
        fail_upd = 1'b1;
      end
      if (new_label > {1'b0, max_label}) begin
        fail_upd = 1'b1;
      end
      label_upd = new_label[dnv_pkg::LABEL_W] ? '1 : new_label[dnv_pkg::LABEL_W-1:0];
      hyph_upd  = cls.hyphen;
    end
    saw_letter_next = saw_letter || cls.upper || cls.lower;
    verdict_next    = !fail_upd && (label_upd != '0) && !hyph_upd && saw_letter_next;

    if (s1_last) begin
      label_count_next     = '0;
      total_count_next     = '0;
      prev_was_hyphen_next = 1'b0;
      failed_next          = 1'b0;
      saw_letter_next      = 1'b0;
    end else begin
      label_count_next     = label_upd;
      total_count_next     = new_total[dnv_pkg::DOM_W] ? '1 : new_total[dnv_pkg::DOM_W-1:0];
      prev_was_hyphen_next = hyph_upd;
      failed_next          = fail_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      o_valid         <= 1'b0;
      label_count     <= '0;
      total_count     <= '0;
      prev_was_hyphen <= 1'b0;
      saw_letter      <= 1'b0;
      failed          <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (adv_out) begin
        o_valid <= s1_valid;
      end
      if (adv_s1) begin
        label_count     <= label_count_next;
        total_count     <= total_count_next;
        prev_was_hyphen <= prev_was_hyphen_next;
        saw_letter      <= saw_letter_next;
        failed          <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char <= in_ch.character;
      s1_last <= in_ch.is_last;
    end
    if (adv_s1) begin
      o_char    <= lowered;
      o_last    <= s1_last;
      o_verdict <= s1_last && verdict_next;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.lower_char  = o_char;
  assign out_ch.end_of_name = o_last;
  assign out_ch.name_valid  = o_verdict;

endmodule

// ===== rtl/core/dnv_checker.sv =====
`timescale 1ns / 1ps

module dnv_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dnv_pkg::CHAR_W-1:0] lower_char,
  input logic                       end_of_name,
  input logic                       name_valid
);

  // stalled result beat must not vanish
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_verdict_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && name_valid) |-> end_of_name)
    else $error("verdict set on a beat that is not the last");

  // a valid name cannot end in a dot or hyphen
  a_valid_tail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && name_valid) |->
      (lower_char != dnv_pkg::CH_DOT) && (lower_char != dnv_pkg::CH_HYPHEN))
    else $error("valid verdict on a name ending in dot or hyphen");

  a_no_upper: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      !((lower_char >= dnv_pkg::CH_UPPER_A) && (lower_char <= dnv_pkg::CH_UPPER_Z)))
    else $error("upper case letter left unfolded");

endmodule

bind domain_name_validator_core dnv_checker u_dnv_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .lower_char  (out_ch.lower_char),
  .end_of_name (out_ch.end_of_name),
  .name_valid  (out_ch.name_valid)
);

// ===== tb/dnv_name_checker.sv =====
`timescale 1ns / 1ps

module dnv_name_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dnv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dnv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dnv_in_if                              in_ch,
  dnv_out_if                             out_ch,
  output int                             pending,
  output int                             mismatches
);
  import dnv_pkg::*;

  localparam int LABEL_SAT = (1 << LABEL_W) - 1;
  localparam int TOTAL_SAT = (1 << DOM_W) - 1;

  typedef struct packed {
    logic [CHAR_W-1:0] lower_char;
    logic              end_of_name;
    logic              name_valid;
  } char_result_t;

  char_result_t       expected_q[$];
  logic [DOM_W-1:0]   dom_limit;
  logic [LABEL_W-1:0] label_limit;
  logic [LABEL_W-1:0] label_len;
  logic [DOM_W-1:0]   name_len;
  logic               after_hyphen;
  logic               has_letter;
  logic               broken;
  int                 fail_cnt = 0;

  function automatic char_result_t fold_char(input logic [CHAR_W-1:0] ch, input logic last);
    logic         up;
    logic         lo;
    logic         dig;
    logic         hy;
    int           new_total;
    int           new_label;
    char_result_t r;
    up  = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);
    lo  = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
    dig = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
    hy  = (ch == CH_HYPHEN);
    new_total = int'(name_len) + 1;
    if (new_total > int'(dom_limit)) broken = 1'b1;
    name_len = (new_total > TOTAL_SAT) ? DOM_W'(TOTAL_SAT) : DOM_W'(new_total);
    if (up || lo) has_letter = 1'b1;
    if (ch == CH_DOT) begin
      if (label_len == '0 || after_hyphen) broken = 1'b1;
      label_len    = '0;
      after_hyphen = 1'b0;
    end else begin
      new_label = int'(label_len) + 1;
      if (!(up || lo || dig || hy)) broken = 1'b1;
      if (label_len == '0 && hy) broken = 1'b1;
      if (new_label > int'(label_limit)) broken = 1'b1;
      label_len    = (new_label > LABEL_SAT) ? LABEL_W'(LABEL_SAT) : LABEL_W'(new_label);
      after_hyphen = hy;
    end
    r.lower_char  = up ? CHAR_W'(ch + CASE_OFFSET) : ch;
    r.end_of_name = last;
    r.name_valid  = 1'b0;
    if (last) begin
      r.name_valid = !broken && label_len != '0 && !after_hyphen && has_letter;
      label_len    = '0;
      name_len     = '0;
      after_hyphen = 1'b0;
      has_letter   = 1'b0;
      broken       = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    char_result_t got;
    char_result_t want;
    if (rst) begin
      dom_limit    = MAX_DOMAIN_RST;
      label_limit  = MAX_LABEL_RST;
      label_len    = '0;
      name_len     = '0;
      after_hyphen = 1'b0;
      has_letter   = 1'b0;
      broken       = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_DOMAIN: dom_limit = cfg_wdata[DOM_W-1:0];
          REG_MAX_LABEL:  label_limit = cfg_wdata[LABEL_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.lower_char, out_ch.end_of_name, out_ch.name_valid};
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: lower_char %h", got.lower_char);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (got.lower_char !== want.lower_char) begin
            $error("lower_char: expected %h, actual %h", want.lower_char, got.lower_char);
            fail_cnt++;
          end
          if (got.end_of_name !== want.end_of_name) begin
            $error("end_of_name: expected %b, actual %b", want.end_of_name, got.end_of_name);
            fail_cnt++;
          end
          if (got.name_valid !== want.name_valid) begin
            $error("name_valid: expected %b, actual %b", want.name_valid, got.name_valid);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(fold_char(in_ch.character, in_ch.is_last));
      end
    end
    pending    <= expected_q.size();
    mismatches <= fail_cnt;
  end

endmodule

// ===== tb/tb_domain_name_validator_core.sv =====
`timescale 1ns / 1ps

module tb_domain_name_validator_core;
  import dnv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;

  typedef logic [CHAR_W-1:0] name_q_t[$];

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    mismatches;

  bit idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  int n_names = 0;
  int n_chars = 0;
  int n_settings = 1;
  int cycles = 0;

  dnv_in_if  in_ch ();
  dnv_out_if out_ch ();

  domain_name_validator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  dnv_name_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 27);
        @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
    while (idle_on && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= ch;
    in_ch.is_last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_chars++;
  endtask

  task automatic send_name(input name_q_t nm);
    foreach (nm[i]) send_char(nm[i], i == nm.size() - 1);
    n_names++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input int dom, input int lab);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_DOMAIN;
    cfg_wdata <= CFG_DATA_W'(dom);
    @(posedge clk);
    cfg_index <= REG_MAX_LABEL;
    cfg_wdata <= CFG_DATA_W'(lab);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  function automatic name_q_t str_name(input string s);
    name_q_t nm;
    for (int i = 0; i < s.len(); i++) nm.push_back(CHAR_W'(s[i]));
    return nm;
  endfunction

  function automatic name_q_t letter_run(input int label_len, input int labels);
    name_q_t nm;
    for (int l = 0; l < labels; l++) begin
      for (int i = 0; i < label_len; i++) begin
        nm.push_back(CHAR_W'(($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + $urandom_range(25)));
      end
      if (l < labels - 1) nm.push_back(CH_DOT);
    end
    return nm;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input bit at_edge);
    int r;
    r = $urandom_range(99);
    if (r < 45) return CHAR_W'(CH_LOWER_A + $urandom_range(25));
    if (r < 70) return CHAR_W'(CH_UPPER_A + $urandom_range(25));
    if (r < 90 || at_edge) return CHAR_W'(CH_DIGIT_0 + $urandom_range(9));
    return CH_HYPHEN;
  endfunction

  // mostly well-formed names; the rest broken in one of several ways
  function automatic name_q_t random_name(input int span);
    name_q_t nm;
    int      labels;
    int      len;
    int      pos;
    int      kind;
    labels = $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      len = $urandom_range(1, span);
      for (int i = 0; i < len; i++) nm.push_back(pick_char(i == 0 || i == len - 1));
      if (l < labels - 1) nm.push_back(CH_DOT);
    end
    kind = $urandom_range(99);
    pos  = $urandom_range(nm.size() - 1);
    if (kind >= 72) begin
      case (kind % 7)
        0: nm.insert(pos, $urandom_range(1) ? CHAR_W'($urandom) : CHAR_W'($urandom_range(127)));
        1: nm.push_front(CH_HYPHEN);
        2: nm.push_back(CH_HYPHEN);
        3: nm.insert(pos, CH_DOT);
        4: nm.push_front(CH_DOT);
        5: nm.push_back(CH_DOT);
        default: begin
          foreach (nm[i]) begin
            if ((nm[i] >= CH_UPPER_A && nm[i] <= CH_UPPER_Z) ||
                (nm[i] >= CH_LOWER_A && nm[i] <= CH_LOWER_Z)) begin
              nm[i] = CHAR_W'(CH_DIGIT_0 + nm[i] % 10);
            end
          end
        end
      endcase
    end
    return nm;
  endfunction

  task automatic run_random(input int budget, input int span);
    int start;
    start = n_chars;
    while (n_chars - start < budget) send_name(random_name(span));
  endtask

  initial begin
    int dom;
    int lab;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_MAX_DOMAIN;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.character <= '0;
    in_ch.is_last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: case folding, hyphen and dot rules, class boundaries, code extremes
    send_name(str_name("aZ"));
    send_name(str_name("-a"));
    send_name(str_name("a-"));
    send_name(str_name("a..b"));
    send_name(str_name(".a"));
    send_name(str_name("a."));
    send_name(str_name("09"));
    send_name(str_name("@[`{"));
    send_name('{CH_LOWER_A, 16'hFFFF, 16'h0000});
    send_name(str_name("x-1.Y"));

    hold_off_req = 1'b1;
    run_random(70, 8);
    drain();
    run_random(30, 8);

    set_limits(1, 1);
    idle_on = 1'b0;
    send_name(str_name("a"));
    send_name(str_name("ab"));
    send_name(str_name("A.b"));
    run_random(20, 2);

    set_limits(1023, 255);
    send_name(letter_run(256, 1));
    run_random(20, 10);

    set_limits(0, 0);
    run_random(10, 3);

    repeat (4) begin
      dom = $urandom_range(4, 40);
      lab = $urandom_range(2, 12);
      set_limits(dom, lab);
      run_random(12, lab + 2);
      idle_on = 1'b1;
    end

    set_limits(MAX_DOMAIN_RST, MAX_LABEL_RST);
    run_random(15, 8);
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d names, %0d characters, under %0d length-limit settings.",
             n_names, n_chars, n_settings);
    $display("Included a saturated label counter, zero limits, output hold-off and drained pauses.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== domain_name_validator_core.f =====
rtl/core/dnv_pkg.sv
rtl/core/dnv_in_if.sv
rtl/core/dnv_out_if.sv
rtl/core/dnv_char_class.sv
rtl/core/domain_name_validator_core.sv
rtl/core/dnv_checker.sv
tb/dnv_name_checker.sv
tb/tb_domain_name_validator_core.sv
